### src/sdme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdme_pkg
// shared types and constants of the shadow depth map engine
// ----------------------------------------------------------------------------
package sdme_pkg;

  localparam int unsigned MapWDefault = 64;
  localparam int unsigned MapHDefault = 64;

  localparam int unsigned CoefW  = 16;
  localparam int unsigned PosW   = 16;
  localparam int unsigned ClipW  = 36;
  localparam int unsigned DepthW = 16;
  localparam logic [DepthW-1:0] DepthFar = '1;
  localparam logic [15:0] BiasReset = 16'd66;

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdSplat = 2'd1,
    CmdQuery = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatDone    = 2'd0,
    StatBehind  = 2'd1,
    StatOutside = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RegRowX = 3'd0,
    RegRowY = 3'd1,
    RegRowZ = 3'd2,
    RegRowW = 3'd3,
    RegBias = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]  command;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
  } in_beat_t;

  typedef struct packed {
    logic       occluded;
    logic [1:0] status;
  } out_beat_t;

endpackage

### src/sdme_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdme_if
// valid/ready channel carrying one beat of a given type
// ----------------------------------------------------------------------------
interface sdme_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/shadow_depth_map_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_depth_map_engine_unit
// light-space projection of points with depth splat and occlusion query
// ----------------------------------------------------------------------------
// One item at a time. A splat or query is accepted and then runs the matrix
// product (one 16x16 multiplier, one coefficient a cycle), finishes the sum
// and checks w and the map edges. It then runs three restoring divisions by
// 2w on one shared divider (x, y and depth; the depth one is skipped when the
// depth clamps to zero). A read of the depth memory follows, with a write of
// the new depth for a splat that is nearer (one port, registered read, states
// StRead, StWait and StUpdate), and the result register is then loaded. A
// point behind the light gives its result straight from the check. A point
// outside the map gives its result from the check, or once the x and y
// divisions have run. A clear sweeps the map, one entry a cycle, and then
// gives its result. An unused command goes straight to the result. After
// reset the same sweep runs before the first item is taken; configuration
// writes are taken throughout. A result waits in an output register while
// the next item is taken and worked on. That item holds in its last state
// until the register is free.
module shadow_depth_map_engine_unit
  import sdme_pkg::*;
#(
  parameter int unsigned MAP_W = MapWDefault,
  parameter int unsigned MAP_H = MapHDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdme_if.sink        in_i,
  sdme_if.source      out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned Depth = MAP_W * MAP_H;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned XW    = $clog2(MAP_W);
  localparam int unsigned YW    = $clog2(MAP_H);
  // quotient bits: enough for values up to the scale (detects overflow)
  localparam int unsigned QXW   = XW + 1;
  localparam int unsigned QYW   = YW + 1;
  localparam int unsigned QZW   = DepthW + 1;
  localparam int unsigned DivW  = ClipW + 2 + QZW;
  localparam int unsigned CntW  = $clog2(QZW + 1);

  typedef enum logic [3:0] {
    StSweep, StIdle, StMac, StCheck, StDivX, StDivY, StDivZ, StRead,
    StWait, StUpdate, StOut
  } state_e;

  // ---------------- configuration ----------------
  logic [63:0] row_q [4];
  logic [15:0] bias_q;
  logic        wr_en;
  logic [2:0]  wr_idx;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) row_q[i] <= '0;
      bias_q <= BiasReset;
    end else if (wr_en) begin
      unique case (wr_idx)
        RegRowX: row_q[0] <= pwdata;
        RegRowY: row_q[1] <= pwdata;
        RegRowZ: row_q[2] <= pwdata;
        RegRowW: row_q[3] <= pwdata;
        RegBias: bias_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[5:3])
      RegRowX: prdata = row_q[0];
      RegRowY: prdata = row_q[1];
      RegRowZ: prdata = row_q[2];
      RegRowW: prdata = row_q[3];
      RegBias: prdata = {48'd0, bias_q};
      default: prdata = '0;
    endcase
  end

  // ---------------- depth memory ----------------
  logic [DepthW-1:0] mem [Depth];
  logic              mem_we;
  logic [AddrW-1:0]  mem_addr;
  logic [DepthW-1:0] mem_wdata;
  logic [DepthW-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_q <= mem[mem_addr];
  end

  // ---------------- datapath ----------------
  state_e              state_q;
  logic [1:0]          cmd_q;
  logic signed [PosW-1:0] pos_q [3];
  logic signed [ClipW-1:0] acc_q [4];
  logic [1:0]          row_cnt_q;
  logic [1:0]          col_cnt_q;
  logic signed [31:0]  prod_q;
  logic                prod_vld_q;
  logic [1:0]          prod_row_q;
  logic [AddrW-1:0]    sweep_q;
  logic [DivW-1:0]     rem_q;
  logic [DivW-1:0]     dvs_q;
  logic [QZW-1:0]      quo_q;
  logic [CntW-1:0]     bit_q;
  logic [QXW-1:0]      qx_q;
  logic [QYW-1:0]      qy_q;
  logic [DepthW-1:0]   dz_q;
  out_beat_t           wrk_q;
  out_beat_t           res_q;
  logic                res_vld_q;
  // the post-reset sweep gives no result; later clears do
  logic                rst_done_q;

  logic [15:0]         coef;
  logic signed [PosW-1:0] mult_b;
  logic [DivW-1:0]     trial;

  always_comb begin
    coef = row_q[row_cnt_q][16*col_cnt_q +: 16];
    unique case (col_cnt_q)
      2'd0: mult_b = pos_q[0];
      2'd1: mult_b = pos_q[1];
      2'd2: mult_b = pos_q[2];
      default: mult_b = PosW'(256);
    endcase
  end

  assign trial = rem_q - dvs_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = sweep_q;
    mem_wdata = DepthFar;
    if (state_q == StSweep) begin
      mem_we = 1'b1;
    end else if (state_q == StRead || state_q == StWait || state_q == StUpdate) begin
      mem_addr = AddrW'(qy_q[QYW-2:0]) * AddrW'(MAP_W) + AddrW'(qx_q[QXW-2:0]);
      if (state_q == StUpdate && cmd_q == CmdSplat && dz_q < mem_rdata_q) begin
        mem_we    = 1'b1;
        mem_wdata = dz_q;
      end
    end
  end

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

  // start a division of (n + w) * scale by 2w
  function automatic logic [DivW-1:0] start_num(logic signed [ClipW-1:0] n,
                                                logic signed [ClipW-1:0] w,
                                                int unsigned scale);
    logic signed [ClipW+1:0] s;
    s = (ClipW+2)'(n) + (ClipW+2)'(w);
    return DivW'(s) * DivW'(scale);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StSweep;
      sweep_q    <= '0;
      res_vld_q  <= 1'b0;
      res_q      <= '0;
      wrk_q      <= '0;
      prod_vld_q <= 1'b0;
      row_cnt_q  <= '0;
      col_cnt_q  <= '0;
      cmd_q      <= '0;
    end else begin
      if (out_o.valid && out_o.ready) res_vld_q <= 1'b0;
      unique case (state_q)
        StSweep: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == AddrW'(Depth - 1)) begin
            sweep_q <= '0;
            state_q <= StOut;
            wrk_q   <= '{occluded: 1'b0, status: StatDone};
          end
        end
        StIdle: begin
          if (in_i.valid && in_i.ready) begin
            cmd_q    <= in_i.data.command;
            pos_q[0] <= in_i.data.pos_x;
            pos_q[1] <= in_i.data.pos_y;
            pos_q[2] <= in_i.data.pos_z;
            wrk_q    <= '{occluded: 1'b0, status: StatDone};
            unique case (cmd_e'(in_i.data.command))
              CmdClear: state_q <= StSweep;
              CmdNone:  state_q <= StOut;
              default: begin
                state_q <= StMac;
                for (int i = 0; i < 4; i++) acc_q[i] <= '0;
                row_cnt_q  <= '0;
                col_cnt_q  <= '0;
                prod_vld_q <= 1'b0;
              end
            endcase
          end
        end
        StMac: begin
          // the product is registered and accumulated in the next cycle
          prod_q     <= $signed(coef) * mult_b;
          prod_vld_q <= 1'b1;
          prod_row_q <= row_cnt_q;
          if (prod_vld_q) acc_q[prod_row_q] <= acc_q[prod_row_q] + ClipW'(prod_q);
          col_cnt_q <= col_cnt_q + 1'b1;
          if (col_cnt_q == 2'd3) row_cnt_q <= row_cnt_q + 1'b1;
          if (col_cnt_q == 2'd3 && row_cnt_q == 2'd3) state_q <= StCheck;
        end
        StCheck: begin
          if (prod_vld_q) begin
            acc_q[prod_row_q] <= acc_q[prod_row_q] + ClipW'(prod_q);
            prod_vld_q <= 1'b0;
          end else if (acc_q[3] <= 0) begin
            wrk_q.status <= StatBehind;
            state_q      <= StOut;
          end else if ((acc_q[0] + acc_q[3]) < 0 || (acc_q[1] + acc_q[3]) < 0) begin
            wrk_q.status <= StatOutside;
            state_q      <= StOut;
          end else begin
            rem_q <= start_num(acc_q[0], acc_q[3], MAP_W);
            dvs_q <= DivW'({acc_q[3], 1'b0}) << (QXW - 1);
            quo_q <= '0;
            bit_q <= CntW'(QXW);
            state_q <= StDivX;
          end
        end
        StDivX, StDivY, StDivZ: begin
          if (bit_q != '0) begin
            if (rem_q >= dvs_q) begin
              rem_q <= trial;
              quo_q <= {quo_q[QZW-2:0], 1'b1};
            end else begin
              quo_q <= {quo_q[QZW-2:0], 1'b0};
            end
            dvs_q <= dvs_q >> 1;
            bit_q <= bit_q - 1'b1;
          end else if (state_q == StDivX) begin
            qx_q  <= quo_q[QXW-1:0];
            rem_q <= start_num(acc_q[1], acc_q[3], MAP_H);
            dvs_q <= DivW'({acc_q[3], 1'b0}) << (QYW - 1);
            quo_q <= '0;
            bit_q <= CntW'(QYW);
            state_q <= StDivY;
          end else if (state_q == StDivY) begin
            qy_q <= quo_q[QYW-1:0];
            if (qx_q >= QXW'(MAP_W) || quo_q[QYW-1:0] >= QYW'(MAP_H)) begin
              wrk_q.status <= StatOutside;
              state_q      <= StOut;
            end else if ((acc_q[2] + acc_q[3]) < 0) begin
              dz_q    <= '0;
              state_q <= StRead;
            end else begin
              rem_q <= start_num(acc_q[2], acc_q[3], 2 ** DepthW);
              dvs_q <= DivW'({acc_q[3], 1'b0}) << (QZW - 1);
              quo_q <= '0;
              bit_q <= CntW'(QZW);
              state_q <= StDivZ;
            end
          end else begin
            dz_q    <= quo_q[QZW-1] ? DepthFar : quo_q[DepthW-1:0];
            state_q <= StRead;
          end
        end
        StRead:   state_q <= StWait;
        StWait:   state_q <= StUpdate;
        StUpdate: begin
          if (cmd_q == CmdQuery)
            wrk_q.occluded <= {1'b0, dz_q} > ({1'b0, mem_rdata_q} + {1'b0, bias_q});
          state_q <= StOut;
        end
        StOut: begin
          if (!res_vld_q) begin
            res_q     <= wrk_q;
            res_vld_q <= (cmd_q != CmdClear) || rst_done_q;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rst_done_q <= 1'b0;
    else if (state_q == StIdle) rst_done_q <= 1'b1;
  end

endmodule

### src/sdme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdme_checker
// port-level checks of the shadow depth map engine
// ----------------------------------------------------------------------------
module sdme_checker
  import sdme_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.status != 2'd3)
    else $error("unused status code");

  a_occ_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.occluded |-> out_data.status == StatDone)
    else $error("occlusion flagged on a failed item");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

bind shadow_depth_map_engine_unit sdme_checker u_sdme_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);
